// ----- hw/rtl/sts_pkg.sv -----
// Shared types and constants for the sphere triangle subdivider.
// No dependencies; the subdivider, lane and output stage import this package.
package sts_pkg;

   localparam int COORD_W     = 16;              // Q1.14 component field
   localparam int IDX_W       = 20;              // vertex index field
   localparam int SUM_W       = COORD_W + 1;     // sum of two components
   localparam int SQ_W        = 2 * SUM_W - 1;   // square of a sum magnitude
   localparam int LEN_W       = SQ_W + 2;        // sum of three squares
   localparam int NUM_MIDS    = 3;
   localparam int NUM_RESULTS = 7;
   localparam int RES_CNT_W   = 3;
   localparam int MID_W       = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [IDX_W-1:0]          index_type;

   localparam index_type IDX_MAX = '1;

   // result slots, in emit order
   localparam logic [RES_CNT_W-1:0] RES_VTX_AB  = 3'd0;
   localparam logic [RES_CNT_W-1:0] RES_VTX_BC  = 3'd1;
   localparam logic [RES_CNT_W-1:0] RES_VTX_AC  = 3'd2;
   localparam logic [RES_CNT_W-1:0] RES_TRI_MID = 3'd3;
   localparam logic [RES_CNT_W-1:0] RES_TRI_A   = 3'd4;
   localparam logic [RES_CNT_W-1:0] RES_TRI_B   = 3'd5;
   localparam logic [RES_CNT_W-1:0] RES_TRI_C   = 3'd6;

   // midpoint numbering
   localparam logic [MID_W-1:0] MID_AB = 2'd0;
   localparam logic [MID_W-1:0] MID_BC = 2'd1;
   localparam logic [MID_W-1:0] MID_AC = 2'd2;

   typedef struct packed {
      coord_type corner_a_x;
      coord_type corner_a_y;
      coord_type corner_a_z;
      coord_type corner_b_x;
      coord_type corner_b_y;
      coord_type corner_b_z;
      coord_type corner_c_x;
      coord_type corner_c_y;
      coord_type corner_c_z;
      index_type corner_a_index;
      index_type corner_b_index;
      index_type corner_c_index;
   } req_type;

   typedef struct packed {
      logic      is_triangle;
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      index_type new_vertex_index;
      index_type tri_first;
      index_type tri_second;
      index_type tri_third;
      logic      overflow;
      logic      last;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   // everything the output stage needs for one triangle
   typedef struct packed {
      vec_type   [NUM_MIDS-1:0] pos;
      index_type [NUM_MIDS-1:0] new_idx;
      logic      [NUM_MIDS-1:0] ovf;
      index_type [NUM_MIDS-1:0] corner_idx;
   } batch_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LENGTH,
      ST_LAUNCH,
      ST_RUN,
      ST_STORE,
      ST_HANDOFF
   } ctrl_state_type;

endpackage

// ----- hw/rtl/sts_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is supplied by the user (see sts_pkg).
interface sts_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/sphere_triangle_subdivider.sv -----
// Top level of the sphere triangle subdivider: control, lanes, merge, output.
// Depends on sts_pkg, sts_stream_if, sts_lane and sts_emit.
//
//   channel    dir   handshake            payload
//   req_chan   in    valid/ready          sts_pkg::req_type (one triangle)
//   rsp_chan   out   valid/ready          sts_pkg::rsp_type (seven items per triangle)
//
// Each triangle is worked one midpoint at a time. Three lanes (x, y, z) take the
// midpoint sum; their squares are merged into the squared length, then each lane
// searches its scaled component bit by bit. Each midpoint passes through the square,
// length, launch, run and store states; a new triangle is accepted only after all
// three midpoints are stored and the batch is handed off. The seven results drain
// from the output stage while the next triangle is being worked; a stalled rsp_chan
// only holds the block once the next batch is finished. Reset is synchronous and
// sets the vertex counter to BASE_VERTICES.
module sphere_triangle_subdivider
   import sts_pkg::*;
#(
   parameter int FRAC_BITS     = 14,
   parameter int BASE_VERTICES = 12
) (
   input  logic          clock,
   input  logic          reset,
   sts_stream_if.sink    req_chan,
   sts_stream_if.source  rsp_chan
);

   ctrl_state_type      state_ff, state_in;
   req_type             corners_ff, corners_in;
   logic [MID_W-1:0]    mid_ff, mid_in;
   index_type           next_ff, next_in;
   batch_type           batch_ff, batch_in;
   logic [LEN_W-1:0]    len_ff, len_in;

   // lane control
   logic                lane_load;
   logic                lane_start;
   logic signed [SUM_W-1:0] lane_sum    [NUM_MIDS];
   logic [SQ_W-1:0]     lane_square [NUM_MIDS];
   logic                lane_done   [NUM_MIDS];
   coord_type           lane_pos    [NUM_MIDS];

   logic                emit_start;
   logic                emit_busy;

   vec_type             va, vb, vc, vp, vq;

   assign va = '{x: corners_ff.corner_a_x, y: corners_ff.corner_a_y, z: corners_ff.corner_a_z};
   assign vb = '{x: corners_ff.corner_b_x, y: corners_ff.corner_b_y, z: corners_ff.corner_b_z};
   assign vc = '{x: corners_ff.corner_c_x, y: corners_ff.corner_c_y, z: corners_ff.corner_c_z};

   // endpoints of the current edge
   always_comb begin
      case (mid_ff)
         MID_AB: begin
            vp = va;
            vq = vb;
         end
         MID_BC: begin
            vp = vb;
            vq = vc;
         end
         MID_AC: begin
            vp = va;
            vq = vc;
         end
         default: begin
            vp = va;
            vq = vb;
         end
      endcase
   end

   // midpoint direction is the plain sum, no halving needed
   assign lane_sum[0] = SUM_W'(vp.x) + SUM_W'(vq.x);
   assign lane_sum[1] = SUM_W'(vp.y) + SUM_W'(vq.y);
   assign lane_sum[2] = SUM_W'(vp.z) + SUM_W'(vq.z);

   for (genvar j = 0; j < NUM_MIDS; j++) begin : g_lane
      sts_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .load   (lane_load),
         .sum    (lane_sum[j]),
         .square (lane_square[j]),
         .start  (lane_start),
         .len2   (len_ff),
         .done   (lane_done[j]),
         .pos    (lane_pos[j])
      );
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      corners_in = corners_ff;
      mid_in     = mid_ff;
      next_in    = next_ff;
      batch_in   = batch_ff;
      len_in     = len_ff;
      lane_load  = 1'b0;
      lane_start = 1'b0;
      emit_start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               corners_in             = req_chan.payload;
               batch_in.corner_idx[0] = req_chan.payload.corner_a_index;
               batch_in.corner_idx[1] = req_chan.payload.corner_b_index;
               batch_in.corner_idx[2] = req_chan.payload.corner_c_index;
               mid_in                 = MID_AB;
               state_in               = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            lane_load = 1'b1;
            state_in  = ST_LENGTH;
         end
         ST_LENGTH: begin
            // merge: squared length from the three lane squares
            len_in   = LEN_W'(lane_square[0]) + LEN_W'(lane_square[1])
                       + LEN_W'(lane_square[2]);
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            lane_start = 1'b1;
            state_in   = ST_RUN;
         end
         ST_RUN: begin
            if (lane_done[0] && lane_done[1] && lane_done[2]) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            batch_in.pos[mid_ff].x   = lane_pos[0];
            batch_in.pos[mid_ff].y   = lane_pos[1];
            batch_in.pos[mid_ff].z   = lane_pos[2];
            batch_in.new_idx[mid_ff] = next_ff;
            // counter saturates at the top index
            if (next_ff == IDX_MAX) begin
               batch_in.ovf[mid_ff] = 1'b1;
            end else begin
               batch_in.ovf[mid_ff] = 1'b0;
               next_in              = next_ff + IDX_W'(1);
            end
            if (mid_ff == MID_AC) begin
               state_in = ST_HANDOFF;
            end else begin
               mid_in   = mid_ff + MID_W'(1);
               state_in = ST_SQUARE;
            end
         end
         ST_HANDOFF: begin
            if (!emit_busy) begin
               emit_start = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_ff  <= IDX_W'(BASE_VERTICES);
         mid_ff   <= MID_AB;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         mid_ff   <= mid_in;
      end
      corners_ff <= corners_in;
      batch_ff   <= batch_in;
      len_ff     <= len_in;
   end

   sts_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .start    (emit_start),
      .batch    (batch_ff),
      .busy     (emit_busy),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- hw/rtl/sts_lane.sv -----
// One normalization lane: scales one sum component onto the unit sphere.
// Bit-by-bit search on q, a trial phase then a compare phase per bit. Uses sts_pkg.
module sts_lane
   import sts_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic signed [SUM_W-1:0] sum,
   output logic [SQ_W-1:0]         square,
   input  logic                    start,
   input  logic [LEN_W-1:0]        len2,
   output logic                    done,
   output coord_type               pos
);

   localparam int QW = FRAC_BITS + 1;
   localparam int TW = 2 * FRAC_BITS + 3;
   localparam int PW = TW + LEN_W;
   localparam int BW = $clog2(FRAC_BITS + 1);
   localparam logic [QW-1:0] Q_MAX = QW'(1) << FRAC_BITS;
   localparam logic [BW-1:0] BIT_TOP = BW'(FRAC_BITS);

   logic [SUM_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               busy_ff, busy_in;
   logic               phase_ff, phase_in;
   logic [BW-1:0]      bit_ff, bit_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [TW-1:0]      tsq_ff, tsq_in;
   logic [QW-1:0]      tq_ff, tq_in;
   logic [TW-1:0]      ttsq_ff, ttsq_in;
   logic               ok_ff, ok_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic               done_ff, done_in;

   logic [2*SUM_W-1:0] sq_full;
   logic [PW-1:0]      rhs;
   logic [COORD_W-1:0] qc;

   assign sq_full = mag_ff * mag_ff;
   assign square  = sq_full[SQ_W-1:0];
   // |s|^2 * 4^(F+1)
   assign rhs     = PW'(square) << (2 * FRAC_BITS + 2);

   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      len_in   = len_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      q_in     = q_ff;
      tsq_in   = tsq_ff;
      tq_in    = tq_ff;
      ttsq_in  = ttsq_ff;
      ok_in    = ok_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;

      if (load) begin
         neg_in = sum[SUM_W-1];
         mag_in = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      end

      if (start) begin
         len_in   = len2;
         busy_in  = 1'b1;
         phase_in = 1'b0;
         bit_in   = BIT_TOP;
         q_in     = '0;
         tsq_in   = TW'(1);               // (2*0 - 1)^2
      end else if (busy_ff) begin
         if (!phase_ff) begin
            // trial q' = q + 2^b, t' = 2q' - 1, t'^2 from t^2 by shifts
            tq_in   = q_ff | (QW'(1) << bit_ff);
            ttsq_in = tsq_ff + (TW'(q_ff) << (bit_ff + 3)) + (TW'(1) << (2 * bit_ff + 2))
                      - (TW'(1) << (bit_ff + 2));
            ok_in   = (tq_in <= Q_MAX);
            prod_in = PW'(ttsq_in) * PW'(len_ff);
            phase_in = 1'b1;
         end else begin
            if (ok_ff && (prod_ff <= rhs)) begin
               q_in   = tq_ff;
               tsq_in = ttsq_ff;
            end
            phase_in = 1'b0;
            if (bit_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      len_ff   <= len_in;
      phase_ff <= phase_in;
      bit_ff   <= bit_in;
      q_ff     <= q_in;
      tsq_ff   <= tsq_in;
      tq_ff    <= tq_in;
      ttsq_ff  <= ttsq_in;
      ok_ff    <= ok_in;
      prod_ff  <= prod_in;
   end

   assign qc   = COORD_W'(q_ff);
   assign done = done_ff;
   // zero-length midpoint goes out as zero
   assign pos  = (len_ff == '0) ? '0 : (neg_ff ? coord_type'(-qc) : coord_type'(qc));

endmodule

// ----- hw/rtl/sts_emit.sv -----
// Output stage: turns one finished batch into seven result items.
// Holds its own copy of the batch and a registered output. Uses sts_pkg.
module sts_emit
   import sts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  batch_type         batch,
   output logic              busy,
   sts_stream_if.source      rsp_chan
);

   logic                  busy_ff, busy_in;
   logic [RES_CNT_W-1:0]  cnt_ff, cnt_in;
   batch_type             batch_ff, batch_in;
   logic                  valid_ff, valid_in;
   rsp_type               data_ff, data_in;
   rsp_type               res;
   logic                  any_ovf;
   logic                  advance;

   assign any_ovf = |batch_ff.ovf;
   assign advance = busy_ff && (!valid_ff || rsp_chan.ready);

   always_comb begin
      res             = '0;
      res.is_triangle = 1'b1;
      res.overflow    = any_ovf;
      case (cnt_ff)
         RES_VTX_AB, RES_VTX_BC, RES_VTX_AC: begin
            res.is_triangle      = 1'b0;
            res.pos_x            = batch_ff.pos[cnt_ff[MID_W-1:0]].x;
            res.pos_y            = batch_ff.pos[cnt_ff[MID_W-1:0]].y;
            res.pos_z            = batch_ff.pos[cnt_ff[MID_W-1:0]].z;
            res.new_vertex_index = batch_ff.new_idx[cnt_ff[MID_W-1:0]];
            res.overflow         = batch_ff.ovf[cnt_ff[MID_W-1:0]];
         end
         RES_TRI_MID: begin
            res.tri_first  = batch_ff.new_idx[MID_AB];
            res.tri_second = batch_ff.new_idx[MID_BC];
            res.tri_third  = batch_ff.new_idx[MID_AC];
         end
         RES_TRI_A: begin
            res.tri_first  = batch_ff.corner_idx[0];
            res.tri_second = batch_ff.new_idx[MID_AB];
            res.tri_third  = batch_ff.new_idx[MID_AC];
         end
         RES_TRI_B: begin
            res.tri_first  = batch_ff.new_idx[MID_AB];
            res.tri_second = batch_ff.corner_idx[1];
            res.tri_third  = batch_ff.new_idx[MID_BC];
         end
         RES_TRI_C: begin
            res.tri_first  = batch_ff.new_idx[MID_BC];
            res.tri_second = batch_ff.corner_idx[2];
            res.tri_third  = batch_ff.new_idx[MID_AC];
            res.last       = 1'b1;
         end
         default: begin
            res = '0;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      batch_in = batch_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      // a held item leaves whenever the sink takes it, start cycle included
      if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = RES_VTX_AB;
         batch_in = batch;
      end else if (advance) begin
         data_in  = res;
         valid_in = 1'b1;
         cnt_in   = cnt_ff + RES_CNT_W'(1);
         if (cnt_ff == RES_TRI_C) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      batch_ff <= batch_in;
      data_ff  <= data_in;
   end

   assign busy             = busy_ff;
   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = data_ff;

endmodule
